/* rtl/core/ffa_pkg.sv */
package ffa_pkg;

    // Fixed field widths of the channels
    localparam int OP_W   = 2;
    localparam int REQ_W  = 13;
    localparam int OFF_W  = 12;
    localparam int OUT_W  = 12;
    // Rounded request: 13-bit request rounded up can reach 8192
    localparam int NEED_W = REQ_W + 1;

    // Operation codes on the request channel
    localparam logic [OP_W-1:0] OP_ALLOC    = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE     = 2'd1;
    localparam logic [OP_W-1:0] OP_COALESCE = 2'd2;
    // Unassigned code: accepted and answered with all-zero fields
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    // Work kinds after classification
    typedef enum logic [1:0] {
        K_ALLOC,
        K_FREE,
        K_COALESCE,
        K_NOP
    } ffa_kind_t;

    // Queue entry between front and back
    typedef struct packed {
        ffa_kind_t          kind;
        logic [NEED_W-1:0]  need;
        logic [OFF_W-1:0]   offset;
    } ffa_item_t;

    // Back-to-front status
    typedef struct packed {
        logic clearing;
        logic pop;
    } ffa_ctl_t;

endpackage

/* rtl/core/ffa_if.sv */
interface ffa_req_if;
    logic                          valid;
    logic                          ready;
    logic [ffa_pkg::OP_W-1:0]      operation;
    logic [ffa_pkg::REQ_W-1:0]     request_bytes;
    logic [ffa_pkg::OFF_W-1:0]     payload_offset;

    modport source (output valid, output operation, output request_bytes,
                    output payload_offset, input ready);
    modport sink   (input valid, input operation, input request_bytes,
                    input payload_offset, output ready);
endinterface

interface ffa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic                          status;
    logic [ffa_pkg::OUT_W-1:0]     granted_offset;
    logic [ffa_pkg::OUT_W-1:0]     freed_bytes;

    modport source (output valid, output status, output granted_offset,
                    output freed_bytes, input ready);
    modport sink   (input valid, input status, input granted_offset,
                    input freed_bytes, output ready);
endinterface

/* rtl/core/ffa_ram.sv */
module ffa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/core/ffa_front.sv */
module ffa_front #(
    parameter int ALIGN_BYTES = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    ffa_req_if.sink             req_ch,
    input  ffa_pkg::ffa_ctl_t   ctl,
    output logic                q_valid,
    output ffa_pkg::ffa_item_t  q_item
);

    localparam int NW = ffa_pkg::NEED_W;

    ffa_pkg::ffa_item_t item;
    logic [NW-1:0]      round_sum;

    ffa_pkg::ffa_item_t fifo_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         cnt_reg, cnt_next;
    logic               push;

    // Classify the request and round the size up to alignment
    always_comb
    begin
        round_sum   = NW'(req_ch.request_bytes) + NW'(ALIGN_BYTES - 1);
        item.need   = round_sum & ~NW'(ALIGN_BYTES - 1);
        item.offset = req_ch.payload_offset;
        unique case (req_ch.operation)
            ffa_pkg::OP_ALLOC:    item.kind = ffa_pkg::K_ALLOC;
            ffa_pkg::OP_FREE:     item.kind = (req_ch.payload_offset == '0) ?
                                              ffa_pkg::K_NOP : ffa_pkg::K_FREE;
            ffa_pkg::OP_COALESCE: item.kind = ffa_pkg::K_COALESCE;
            default:              item.kind = ffa_pkg::K_NOP;
        endcase
    end

    // Two-entry queue toward the back end
    assign req_ch.ready = (cnt_reg != 2'd2) && !ctl.clearing;
    assign push         = req_ch.valid && req_ch.ready;
    assign q_valid      = (cnt_reg != 2'd0);
    assign q_item       = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ ctl.pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(ctl.pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= item;
        end
    end

endmodule

/* rtl/core/ffa_back.sv */
module ffa_back #(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 16,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  ffa_pkg::ffa_item_t  q_item,
    output ffa_pkg::ffa_ctl_t   ctl,
    ffa_rsp_if.source           rsp_ch
);

    localparam int WORDS = POOL_BYTES / ALIGN_BYTES;
    localparam int WB    = $clog2(WORDS);
    localparam int LW    = WB + 1;
    localparam int PB    = $clog2(POOL_BYTES);
    localparam int SW    = PB + 1;
    localparam int AB    = $clog2(ALIGN_BYTES);
    localparam int HW    = HEADER_BYTES / ALIGN_BYTES;
    localparam int NW    = ffa_pkg::NEED_W;
    localparam int CMPW  = ((SW > NW) ? SW : NW) + 2;
    localparam int LIMIT = 4 * WORDS + 4;
    localparam int CW    = $clog2(LIMIT + 1);
    localparam int OW    = ffa_pkg::OUT_W;
    localparam logic [LW-1:0] NIL = LW'(WORDS);

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_A_CHK,
        S_A_GOT,
        S_A_SPL2,
        S_C_RD,
        S_C_GOTC,
        S_C_GOTN,
        S_F_GOT
    } state_t;

    state_t            state_reg, state_next;
    logic [WB-1:0]     clr_reg, clr_next;
    logic [LW-1:0]     head_reg, head_next;
    logic [LW-1:0]     cur_reg, cur_next;
    logic [LW-1:0]     prev_reg, prev_next;
    logic [CW-1:0]     steps_reg, steps_next;
    logic [NW-1:0]     need_reg, need_next;
    logic [SW-1:0]     sc_reg, sc_next;
    logic [LW-1:0]     lc_reg, lc_next;
    logic [WB-1:0]     nw_reg, nw_next;
    logic              vld_reg, vld_next;
    logic              status_reg, status_next;
    logic [OW-1:0]     grant_reg, grant_next;
    logic [OW-1:0]     freed_reg, freed_next;

    // Memory ports
    logic              s_we, l_we;
    logic [WB-1:0]     s_wa, l_wa, s_ra, l_ra;
    logic [SW-1:0]     s_wd, s_rd;
    logic [LW-1:0]     l_wd, l_rd;

    // Datapath terms
    logic              pop;
    logic              walk_ok;
    logic [WB-1:0]     c_idx;
    logic [WB-1:0]     n_idx;
    logic [CMPW-1:0]   need_ext;
    logic [CMPW-1:0]   sz_ext;
    logic [CMPW-1:0]   split_at;
    logic [CMPW-1:0]   c_base;
    logic [CMPW-1:0]   c_end;
    logic [CMPW-1:0]   n_base;
    logic [CMPW-1:0]   free_diff;
    logic [WB-1:0]     free_word;

    ffa_ram #(.WIDTH(SW), .DEPTH(WORDS)) u_size_ram (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_wa),
        .wdata (s_wd),
        .raddr (s_ra),
        .rdata (s_rd)
    );

    ffa_ram #(.WIDTH(LW), .DEPTH(WORDS)) u_link_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (l_wa),
        .wdata (l_wd),
        .raddr (l_ra),
        .rdata (l_rd)
    );

    assign pop          = (state_reg == S_IDLE) && q_valid && (!vld_reg || rsp_ch.ready);
    assign ctl.pop      = pop;
    assign ctl.clearing = (state_reg == S_CLR);

    assign rsp_ch.valid          = vld_reg;
    assign rsp_ch.status         = status_reg;
    assign rsp_ch.granted_offset = grant_reg;
    assign rsp_ch.freed_bytes    = freed_reg;

    // Address arithmetic
    always_comb
    begin
        walk_ok   = (cur_reg != NIL) && (steps_reg < CW'(LIMIT));
        c_idx     = cur_reg[WB-1:0];
        n_idx     = lc_reg[WB-1:0];
        need_ext  = CMPW'(need_reg);
        sz_ext    = CMPW'(s_rd);
        split_at  = CMPW'(c_idx) + CMPW'(HW) + (need_ext >> AB);
        c_base    = (CMPW'(c_idx) << AB) + CMPW'(HEADER_BYTES);
        c_end     = c_base + CMPW'(sc_reg);
        n_base    = CMPW'(n_idx) << AB;
        free_diff = CMPW'(q_item.offset) - CMPW'(HEADER_BYTES);
        free_word = free_diff[PB-1:AB];
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        clr_next    = clr_reg;
        head_next   = head_reg;
        cur_next    = cur_reg;
        prev_next   = prev_reg;
        steps_next  = steps_reg;
        need_next   = need_reg;
        sc_next     = sc_reg;
        lc_next     = lc_reg;
        nw_next     = nw_reg;
        status_next = status_reg;
        grant_next  = grant_reg;
        freed_next  = freed_reg;
        vld_next    = vld_reg && !rsp_ch.ready;
        s_we = 1'b0;
        s_wa = '0;
        s_wd = '0;
        s_ra = '0;
        l_we = 1'b0;
        l_wa = '0;
        l_wd = '0;
        l_ra = '0;

        unique case (state_reg)
            S_CLR:
            begin
                s_we = 1'b1;
                s_wa = clr_reg;
                s_wd = (clr_reg == '0) ? SW'(POOL_BYTES - HEADER_BYTES) : '0;
                l_we = 1'b1;
                l_wa = clr_reg;
                l_wd = (clr_reg == '0) ? NIL : '0;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == WB'(WORDS - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (pop)
                begin
                    unique case (q_item.kind)
                        ffa_pkg::K_ALLOC:
                        begin
                            need_next  = q_item.need;
                            cur_next   = head_reg;
                            prev_next  = NIL;
                            steps_next = '0;
                            state_next = S_A_CHK;
                        end
                        ffa_pkg::K_FREE:
                        begin
                            l_we       = 1'b1;
                            l_wa       = free_word;
                            l_wd       = head_reg;
                            s_ra       = free_word;
                            head_next  = LW'(free_word);
                            state_next = S_F_GOT;
                        end
                        ffa_pkg::K_COALESCE:
                        begin
                            cur_next   = head_reg;
                            steps_next = '0;
                            state_next = S_C_RD;
                        end
                        default:
                        begin
                            vld_next    = 1'b1;
                            status_next = 1'b0;
                            grant_next  = '0;
                            freed_next  = '0;
                        end
                    endcase
                end
            end

            S_A_CHK:
            begin
                if (walk_ok)
                begin
                    s_ra       = c_idx;
                    l_ra       = c_idx;
                    state_next = S_A_GOT;
                end
                else
                begin
                    vld_next    = 1'b1;
                    status_next = 1'b1;
                    grant_next  = '0;
                    freed_next  = '0;
                    state_next  = S_IDLE;
                end
            end

            S_A_GOT:
            begin
                if (sz_ext >= need_ext)
                begin
                    vld_next    = 1'b1;
                    status_next = 1'b0;
                    grant_next  = c_base[OW-1:0];
                    freed_next  = '0;
                    if (sz_ext >= need_ext + CMPW'(HEADER_BYTES + ALIGN_BYTES))
                    begin
                        // Split: remainder header goes in first
                        s_we       = 1'b1;
                        s_wa       = split_at[WB-1:0];
                        s_wd       = SW'(sz_ext - need_ext - CMPW'(HEADER_BYTES));
                        l_we       = 1'b1;
                        l_wa       = split_at[WB-1:0];
                        l_wd       = l_rd;
                        nw_next    = split_at[WB-1:0];
                        state_next = S_A_SPL2;
                    end
                    else
                    begin
                        // Unlink whole block
                        if (prev_reg == NIL)
                        begin
                            head_next = l_rd;
                        end
                        else
                        begin
                            l_we = 1'b1;
                            l_wa = prev_reg[WB-1:0];
                            l_wd = l_rd;
                        end
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    prev_next  = LW'(c_idx);
                    cur_next   = l_rd;
                    steps_next = steps_reg + 1'b1;
                    state_next = S_A_CHK;
                end
            end

            S_A_SPL2:
            begin
                s_we = 1'b1;
                s_wa = c_idx;
                s_wd = SW'(need_ext);
                if (prev_reg == NIL)
                begin
                    head_next = LW'(nw_reg);
                end
                else
                begin
                    l_we = 1'b1;
                    l_wa = prev_reg[WB-1:0];
                    l_wd = LW'(nw_reg);
                end
                state_next = S_IDLE;
            end

            S_C_RD:
            begin
                if (walk_ok)
                begin
                    s_ra       = c_idx;
                    l_ra       = c_idx;
                    state_next = S_C_GOTC;
                end
                else
                begin
                    vld_next    = 1'b1;
                    status_next = 1'b0;
                    grant_next  = '0;
                    freed_next  = '0;
                    state_next  = S_IDLE;
                end
            end

            S_C_GOTC:
            begin
                sc_next = s_rd;
                lc_next = l_rd;
                if (l_rd == NIL)
                begin
                    vld_next    = 1'b1;
                    status_next = 1'b0;
                    grant_next  = '0;
                    freed_next  = '0;
                    state_next  = S_IDLE;
                end
                else
                begin
                    s_ra       = l_rd[WB-1:0];
                    l_ra       = l_rd[WB-1:0];
                    state_next = S_C_GOTN;
                end
            end

            S_C_GOTN:
            begin
                if (c_end == n_base)
                begin
                    // Merge successor into current block
                    s_we = 1'b1;
                    s_wa = c_idx;
                    s_wd = SW'(CMPW'(sc_reg) + sz_ext + CMPW'(HEADER_BYTES));
                    l_we = 1'b1;
                    l_wa = c_idx;
                    l_wd = l_rd;
                end
                else
                begin
                    cur_next = LW'(n_idx);
                end
                steps_next = steps_reg + 1'b1;
                state_next = S_C_RD;
            end

            S_F_GOT:
            begin
                vld_next    = 1'b1;
                status_next = 1'b0;
                grant_next  = '0;
                freed_next  = sz_ext[OW-1:0];
                state_next  = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            head_reg  <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            head_reg  <= head_next;
            vld_reg   <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        prev_reg   <= prev_next;
        steps_reg  <= steps_next;
        need_reg   <= need_next;
        sc_reg     <= sc_next;
        lc_reg     <= lc_next;
        nw_reg     <= nw_next;
        status_reg <= status_next;
        grant_reg  <= grant_next;
        freed_reg  <= freed_next;
    end

    // No work is taken while the pool is being initialized
    a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLR) |-> !pop)
        else $error("item taken during clearing pass");

    // A new item only starts when the result register can take its result
    a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (!vld_reg || rsp_ch.ready))
        else $error("item started with result register blocked");

    // A no-fit result carries no offset and no size
    a_nofit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && status_reg) |-> (grant_reg == '0 && freed_reg == '0))
        else $error("no-fit result with nonzero fields");

    // A held result stays put until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg && !rsp_ch.ready) |=> (vld_reg && $stable(grant_reg)
                                        && $stable(freed_reg)))
        else $error("result changed while stalled");

endmodule

/* rtl/core/first_fit_free_list_allocator_unit.sv */
// Channel   Role     Payload
// req_ch    sink     operation, request_bytes, payload_offset
// rsp_ch    source   status, granted_offset, freed_bytes
//
// After reset the size and link memories are initialized, one word per cycle;
// requests are held off meanwhile. No-op items are answered from the idle
// state, and a free answers from S_F_GOT with the freed size. Allocate and
// coalesce read each list block and then act on it, as each memory has a single
// read port. A two-entry queue takes requests
// while the back end works, and a result register holds the result under
// stall; the next item starts once that register is free or being drained.
module first_fit_free_list_allocator_unit #(
    parameter int POOL_BYTES   = 4096,
    parameter int HEADER_BYTES = 16,
    parameter int ALIGN_BYTES  = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    ffa_req_if.sink    req_ch,
    ffa_rsp_if.source  rsp_ch
);

    ffa_pkg::ffa_ctl_t  ctl;
    logic               q_valid;
    ffa_pkg::ffa_item_t q_item;

    ffa_front #(.ALIGN_BYTES(ALIGN_BYTES)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req_ch  (req_ch),
        .ctl     (ctl),
        .q_valid (q_valid),
        .q_item  (q_item)
    );

    ffa_back #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (q_item),
        .ctl     (ctl),
        .rsp_ch  (rsp_ch)
    );

endmodule

/* tb/tb_first_fit_free_list_allocator_unit.sv */
module tb_first_fit_free_list_allocator_unit;

    localparam int POOL   = 4096;
    localparam int HDR    = 16;
    localparam int ALN    = 8;
    localparam int WORDS  = POOL / ALN;
    localparam int NIL    = WORDS;
    localparam int WALK_MAX = 4 * WORDS + 4;
    localparam int IDLE_LIMIT = 200000;

    typedef struct packed {
        logic                    status;
        logic [ffa_pkg::OUT_W-1:0] granted;
        logic [ffa_pkg::OUT_W-1:0] freed;
    } alloc_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ffa_req_if req_ch ();
    ffa_rsp_if rsp_ch ();

    first_fit_free_list_allocator_unit uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .req_ch (req_ch.sink),
        .rsp_ch (rsp_ch.source)
    );

    always #5 clk = ~clk;

    // Shadow copy of the pool bookkeeping
    int unsigned pool_head;
    int unsigned pool_size [WORDS];
    int unsigned pool_link [WORDS];
    alloc_result_t pending_results[$];
    int unsigned live_offsets[$];
    int errors = 0;
    int sent = 0;
    int received = 0;
    int allocs_ok = 0;
    int allocs_nofit = 0;
    int idle_cycles = 0;

    task automatic report_mismatch(input string what, input int got, input int exp_v);
        $display("mismatch %s: got %0d expected %0d (result %0d)", what, got, exp_v, received);
        errors++;
    endtask

    function automatic void pool_reset();
        for (int i = 0; i < WORDS; i++)
        begin
            pool_size[i] = 0;
            pool_link[i] = 0;
        end
        pool_head = 0;
        pool_size[0] = POOL - HDR;
        pool_link[0] = NIL;
    endfunction

    function automatic void relink(int unsigned prev, int unsigned target);
        if (prev == NIL)
            pool_head = target;
        else
            pool_link[prev % WORDS] = target;
    endfunction

    // Predict one result and advance the shadow state
    function automatic alloc_result_t pool_step(logic [ffa_pkg::OP_W-1:0] op,
                                                logic [ffa_pkg::REQ_W-1:0] req,
                                                logic [ffa_pkg::OFF_W-1:0] off);
        alloc_result_t r;
        longint unsigned need, sz, at, hb;
        int unsigned prev, cur, c, n, nw, steps;
        r = '0;
        if (op == ffa_pkg::OP_ALLOC)
        begin
            need = (longint'(req) + ALN - 1) & ~longint'(ALN - 1);
            prev = NIL;
            cur = pool_head;
            steps = 0;
            r.status = 1'b1;
            while (cur != NIL && steps < WALK_MAX)
            begin
                c = cur % WORDS;
                sz = pool_size[c];
                if (sz >= need)
                begin
                    if (sz >= need + HDR + ALN)
                    begin
                        at = longint'(c) * ALN + HDR + need;
                        nw = 32'((at / ALN) % WORDS);
                        pool_size[nw] = 32'(sz - need - HDR);
                        pool_link[nw] = pool_link[c];
                        pool_size[c] = 32'(need);
                        relink(prev, nw);
                    end
                    else
                        relink(prev, pool_link[c]);
                    r.status = 1'b0;
                    r.granted = 12'(c * ALN + HDR);
                    break;
                end
                prev = c;
                cur = pool_link[c];
                steps++;
            end
        end
        else if (op == ffa_pkg::OP_FREE)
        begin
            if (off != 0)
            begin
                hb = (longint'(off) + POOL * 4 - HDR) % POOL;
                c = 32'((hb / ALN) % WORDS);
                pool_link[c] = pool_head;
                pool_head = c;
                r.freed = 12'(pool_size[c]);
            end
        end
        else if (op == ffa_pkg::OP_COALESCE)
        begin
            cur = pool_head;
            steps = 0;
            while (cur != NIL && steps < WALK_MAX)
            begin
                c = cur % WORDS;
                if (pool_link[c] == NIL)
                    break;
                n = pool_link[c] % WORDS;
                if (longint'(c) * ALN + HDR + pool_size[c] == longint'(n) * ALN)
                begin
                    pool_size[c] = pool_size[c] + pool_size[n] + HDR;
                    pool_link[c] = pool_link[n];
                end
                else
                    cur = n;
                steps++;
            end
        end
        return r;
    endfunction

    function automatic int short_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // One transfer on the request channel; valid stays up for a following item
    task automatic send_item(input logic [ffa_pkg::OP_W-1:0] op,
                             input logic [ffa_pkg::REQ_W-1:0] req,
                             input logic [ffa_pkg::OFF_W-1:0] off, input bit allow_gap);
        alloc_result_t r;
        int gap;
        gap = allow_gap ? short_gap() : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid          <= 1'b1;
        req_ch.operation      <= op;
        req_ch.request_bytes  <= req;
        req_ch.payload_offset <= off;
        do
            @(posedge clk);
        while (!req_ch.ready);
        r = pool_step(op, req, off);
        if (op == ffa_pkg::OP_ALLOC && !r.status)
        begin
            live_offsets.push_back(r.granted);
            allocs_ok++;
        end
        else if (op == ffa_pkg::OP_ALLOC)
            allocs_nofit++;
        pending_results.push_back(r);
        sent++;
    endtask

    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Random live block; null when none is held
    function automatic logic [ffa_pkg::OFF_W-1:0] take_live();
        int k;
        logic [ffa_pkg::OFF_W-1:0] o;
        if (live_offsets.size() == 0)
            return '0;
        k = $urandom_range(0, live_offsets.size() - 1);
        o = 12'(live_offsets[k]);
        live_offsets.delete(k);
        return o;
    endfunction

    // Result stall pattern: runs of no stalls alternate with random stalls
    int stall_mode = 0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if ($urandom_range(0, 199) == 0)
                stall_mode <= $urandom_range(0, 2);
            case (stall_mode)
                0: rsp_ch.ready <= 1'b1;
                1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                default: rsp_ch.ready <= ($urandom_range(0, 15) == 0);
            endcase
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result transfer");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (rsp_ch.status !== e.status)
                    report_mismatch("status", rsp_ch.status, e.status);
                if (rsp_ch.granted_offset !== e.granted)
                    report_mismatch("granted_offset", rsp_ch.granted_offset, e.granted);
                if (rsp_ch.freed_bytes !== e.freed)
                    report_mismatch("freed_bytes", rsp_ch.freed_bytes, e.freed);
            end
            received++;
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog expired, %0d results outstanding", pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    // Field extremes, rounding, exact fit, no fit, null and op three
    task automatic test_directed();
        send_item(ffa_pkg::OP_ALLOC, 13'd0, '0, 0);
        send_item(ffa_pkg::OP_ALLOC, 13'd1, '0, 0);
        send_item(ffa_pkg::OP_ALLOC, 13'd8191, 12'hFFF, 0);
        send_item(ffa_pkg::OP_ALLOC, 13'd4096, '0, 0);
        send_item(ffa_pkg::OP_FREE, '0, 12'd0, 0);
        send_item(ffa_pkg::OP_FREE, 13'h1FFF, take_live(), 0);
        send_item(ffa_pkg::OP_COALESCE, 13'h1FFF, 12'hFFF, 0);
        send_item(ffa_pkg::OP_RESERVED, 13'h1FFF, 12'hFFF, 0);
        send_item(ffa_pkg::OP_RESERVED, '0, '0, 0);
        send_item(ffa_pkg::OP_ALLOC, 13'd17, '0, 0);
        send_item(ffa_pkg::OP_ALLOC, 13'd40, '0, 0);
        send_item(ffa_pkg::OP_ALLOC, 13'd7, '0, 0);
        while (live_offsets.size() != 0)
            send_item(ffa_pkg::OP_FREE, '0, take_live(), 0);
        send_item(ffa_pkg::OP_COALESCE, '0, '0, 0);
        // nearly whole pool: exact-fit unlink and split remainders
        send_item(ffa_pkg::OP_ALLOC, 13'd4072, '0, 0);
        send_item(ffa_pkg::OP_ALLOC, 13'd8, '0, 0);
        while (live_offsets.size() != 0)
            send_item(ffa_pkg::OP_FREE, '0, take_live(), 0);
        send_item(ffa_pkg::OP_COALESCE, '0, '0, 0);
        send_item(ffa_pkg::OP_ALLOC, 13'd4080, '0, 0);
        send_item(ffa_pkg::OP_FREE, '0, take_live(), 0);
        // unchecked frees: wrap below header and odd offsets
        send_item(ffa_pkg::OP_FREE, '0, 12'd8, 0);
        send_item(ffa_pkg::OP_FREE, '0, 12'hFFF, 0);
        drain();
    endtask

    // Random alloc/free traffic mixed with coalescing, reserved ops and frees at random offsets
    task automatic test_random_traffic(input int count);
        int pick;
        logic [ffa_pkg::REQ_W-1:0] req;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                req = ($urandom_range(0, 19) == 0) ? 13'($urandom_range(0, 8191))
                                                   : 13'($urandom_range(0, 200));
                send_item(ffa_pkg::OP_ALLOC, req, 12'($urandom), 1);
            end
            else if (pick < 85 && live_offsets.size() != 0)
                send_item(ffa_pkg::OP_FREE, 13'($urandom), take_live(), 1);
            else if (pick < 93)
                send_item(ffa_pkg::OP_COALESCE, 13'($urandom), 12'($urandom), 1);
            else if (pick < 96)
                send_item(ffa_pkg::OP_RESERVED, 13'($urandom), 12'($urandom), 1);
            else
                send_item(ffa_pkg::OP_FREE, 13'($urandom),
                          (pick == 99) ? 12'd0 : 12'($urandom), 1);
            // hold the sender until the back end has caught up
            if (i % 300 == 150)
                drain();
        end
        drain();
    endtask

    initial
    begin
        req_ch.valid          <= 1'b0;
        req_ch.operation      <= ffa_pkg::OP_ALLOC;
        req_ch.request_bytes  <= '0;
        req_ch.payload_offset <= '0;
        pool_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_random_traffic(1350);
        repeat (50) @(posedge clk);
        $display("sent %0d requests, checked %0d results", sent, received);
        $display("allocations granted %0d, no fit %0d", allocs_ok, allocs_nofit);
        if (errors == 0 && pending_results.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* sim.f */
rtl/core/ffa_pkg.sv
rtl/core/ffa_if.sv
rtl/core/ffa_ram.sv
rtl/core/ffa_front.sv
rtl/core/ffa_back.sv
rtl/core/first_fit_free_list_allocator_unit.sv
tb/tb_first_fit_free_list_allocator_unit.sv
